// ===== hw/rtl/cffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_pkg: shared types and constants of the contiguous first-fit allocator
// Holds the result codes, field widths, the register map and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cffa_pkg;

    localparam int KEY_W    = 64;
    localparam int REQ_W    = 9;
    localparam int STATUS_W = 3;
    localparam int FIRST_W  = 8;
    localparam int TOTAL_W  = 9;
    localparam int CFG_W    = 9;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic [0:0] REG_BLOCKS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RESET = 9'd256;

    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DIR_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic    accept;      // latch a new request and restart the directory walk
        logic    dscan;       // one step of the directory walk
        logic    scan_start;  // restart the free-run search at block zero
        logic    scan;        // one step of the free-run search
        logic    fill_start;  // point the fill sweep at the current file
        logic    fill_step;   // write one map bit and advance
        logic    fill_one;    // value written by the fill sweep
        logic    commit;      // update the directory
        logic    load_result; // load the output register
        status_t code;        // result code to load
    } cffa_cmd_t;

    typedef struct packed {
        logic dscan_done;
        logic hit;
        logic free_found;
        logic scan_found;
        logic scan_end;
        logic fill_last;
        logic blk_last;
        logic len_zero;
        logic req_zero;
        logic managed_zero;
        logic op_delete;
        logic out_free;
    } cffa_stat_t;

endpackage

// ===== hw/rtl/cffa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_ctrl: sequencing controller of the allocator
// Runs the map clearing pass after reset, then steps each request through the
// directory walk, the free-run search, the map fill and the directory update.
// ----------------------------------------------------------------------------
module cffa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cffa_pkg::cffa_stat_t stat,
    output cffa_pkg::cffa_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DSCAN  = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_MSCAN  = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    cffa_pkg::status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            code_reg  <= cffa_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.fill_step = 1'b1;
                if (stat.blk_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DSCAN;
                end
            end
            S_DSCAN: begin
                cmd.dscan = 1'b1;
                if (stat.dscan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                code_next = cffa_pkg::ST_OK;
                if (stat.op_delete) begin
                    if (!stat.hit) begin
                        code_next  = cffa_pkg::ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else if (stat.len_zero) begin
                        state_next = S_COMMIT;
                    end else begin
                        cmd.fill_start = 1'b1;
                        state_next     = S_FILL;
                    end
                end else if (stat.hit) begin
                    code_next  = cffa_pkg::ST_EXISTS;
                    state_next = S_DONE;
                end else if (!stat.free_found) begin
                    code_next  = cffa_pkg::ST_DIR_FULL;
                    state_next = S_DONE;
                end else if (stat.managed_zero) begin
                    code_next  = cffa_pkg::ST_NO_SPACE;
                    state_next = S_DONE;
                end else if (stat.req_zero) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_MSCAN;
                end
            end
            S_MSCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_found) begin
                    state_next = S_FILL;
                end else if (stat.scan_end) begin
                    code_next  = cffa_pkg::ST_NO_SPACE;
                    state_next = S_DONE;
                end
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                cmd.fill_one  = !stat.op_delete;
                if (stat.fill_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cffa_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_dpath: datapath of the allocator
// Holds the block map memory, the directory memory with its valid bits, the
// walk counters, the free-run tracker and the output register.
// ----------------------------------------------------------------------------
module cffa_dpath #(
    parameter int NUM_BLOCKS  = 256,
    parameter int DIR_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cffa_pkg::cffa_cmd_t           cmd,
    output cffa_pkg::cffa_stat_t          stat,
    input  logic [cffa_pkg::CFG_W-1:0]    blocks_in_use,
    input  logic                          in_operation,
    input  logic [cffa_pkg::KEY_W-1:0]    in_file_key,
    input  logic [cffa_pkg::REQ_W-1:0]    in_request_blocks,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [cffa_pkg::STATUS_W-1:0] out_status,
    output logic [cffa_pkg::FIRST_W-1:0]  out_first_block,
    output logic [cffa_pkg::TOTAL_W-1:0]  out_block_total
);

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int BW  = $clog2(NUM_BLOCKS + 1);
    localparam int CW  = (BW > 10) ? BW : 10;
    localparam int EW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int DEW = $clog2(DIR_ENTRIES + 1);
    localparam int KW  = cffa_pkg::KEY_W;
    localparam int RW  = cffa_pkg::REQ_W;
    localparam int DW  = KW + AW + RW;

    // Memories
    logic          map_mem [NUM_BLOCKS];
    logic          map_rd_reg;
    logic [DW-1:0] dir_mem [DIR_ENTRIES];
    logic [DW-1:0] dir_rd_reg;

    // Request
    logic          op_reg;
    logic [KW-1:0] key_reg;
    logic [RW-1:0] req_reg;
    logic [AW-1:0] cur_start_reg;
    logic [RW-1:0] cur_len_reg;

    // Directory walk
    logic [DIR_ENTRIES-1:0] valid_reg;
    logic [DEW-1:0]         de_reg;
    logic                   dpend_reg, dpv_reg;
    logic [EW-1:0]          dproc_reg, free_reg, hit_idx_reg;
    logic                   free_found_reg, hit_reg;

    // Map walk
    logic [BW-1:0] blk_reg;
    logic [RW-1:0] rem_reg, run_reg;
    logic          spend_reg;
    logic [AW-1:0] sproc_reg;

    // Output register
    logic                          m_tvalid_reg;
    logic [cffa_pkg::STATUS_W-1:0] status_reg;
    logic [cffa_pkg::FIRST_W-1:0]  first_reg;
    logic [cffa_pkg::TOTAL_W-1:0]  total_reg;

    logic [CW-1:0] managed;
    logic [EW-1:0] de_idx;
    logic [AW-1:0] blk_idx;
    logic          dissue, sissue, key_match, scan_found, fill_last;
    logic [CW-1:0] found_start;
    logic [KW-1:0] rd_key;
    logic [AW-1:0] rd_start;
    logic [RW-1:0] rd_len;
    logic          map_we, map_re, dir_re;

    assign managed = (CW'(blocks_in_use) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                            : CW'(blocks_in_use);
    assign de_idx  = de_reg[EW-1:0];
    assign blk_idx = blk_reg[AW-1:0];

    assign {rd_key, rd_start, rd_len} = dir_rd_reg;

    assign dissue    = (de_reg < DEW'(DIR_ENTRIES));
    assign key_match = dpend_reg && dpv_reg && (rd_key == key_reg);

    assign sissue      = (CW'(blk_reg) < managed);
    assign scan_found  = spend_reg && !map_rd_reg && ((run_reg + 1'b1) == req_reg);
    assign found_start = CW'(sproc_reg) + CW'(1) - CW'(req_reg);
    assign fill_last   = (rem_reg == RW'(1)) || (blk_reg == BW'(NUM_BLOCKS - 1));

    assign map_we = cmd.fill_step;
    assign map_re = cmd.scan && sissue;
    assign dir_re = cmd.dscan && dissue;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[blk_idx] <= cmd.fill_one;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[blk_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && (op_reg == cffa_pkg::OP_CREATE)) begin
            dir_mem[free_reg] <= {key_reg, cur_start_reg, req_reg};
        end
        if (dir_re) begin
            dir_rd_reg <= dir_mem[de_idx];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            blk_reg        <= '0;
            dpend_reg      <= 1'b0;
            spend_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                dpend_reg      <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.dscan) begin
                dpend_reg <= dissue;
                if (dissue && !valid_reg[de_idx] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (key_match) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.scan_start) begin
                blk_reg   <= '0;
                spend_reg <= 1'b0;
            end
            if (cmd.scan) begin
                spend_reg <= sissue;
                if (scan_found) begin
                    blk_reg <= BW'(found_start);
                end else if (sissue) begin
                    blk_reg <= blk_reg + 1'b1;
                end
            end
            if (cmd.fill_start) begin
                blk_reg <= BW'(cur_start_reg);
            end
            if (cmd.fill_step) begin
                blk_reg <= blk_reg + 1'b1;
            end
            if (cmd.commit) begin
                if (op_reg == cffa_pkg::OP_CREATE) begin
                    valid_reg[free_reg] <= 1'b1;
                end else begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
            if (cmd.load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg        <= in_operation;
            key_reg       <= in_file_key;
            req_reg       <= in_request_blocks;
            cur_start_reg <= '0;
            cur_len_reg   <= in_request_blocks;
            de_reg        <= '0;
        end
        if (cmd.dscan) begin
            if (dissue) begin
                de_reg    <= de_reg + 1'b1;
                dpv_reg   <= valid_reg[de_idx];
                dproc_reg <= de_idx;
                if (!valid_reg[de_idx] && !free_found_reg) begin
                    free_reg <= de_idx;
                end
            end
            if (key_match) begin
                hit_idx_reg   <= dproc_reg;
                cur_start_reg <= rd_start;
                cur_len_reg   <= rd_len;
            end
        end
        if (cmd.scan_start) begin
            run_reg <= '0;
        end
        if (cmd.scan) begin
            if (sissue) begin
                sproc_reg <= blk_idx;
            end
            if (spend_reg) begin
                run_reg <= map_rd_reg ? '0 : (run_reg + 1'b1);
            end
            if (scan_found) begin
                cur_start_reg <= found_start[AW-1:0];
                rem_reg       <= req_reg;
            end
        end
        if (cmd.fill_start) begin
            rem_reg <= cur_len_reg;
        end
        if (cmd.fill_step) begin
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.load_result) begin
            status_reg <= cmd.code;
            if (cmd.code == cffa_pkg::ST_OK) begin
                first_reg <= cffa_pkg::FIRST_W'(cur_start_reg);
                total_reg <= cur_len_reg;
            end else begin
                first_reg <= '0;
                total_reg <= '0;
            end
        end
    end

    always_comb begin
        stat              = '0;
        stat.dscan_done   = !dpend_reg && !dissue;
        stat.hit          = hit_reg;
        stat.free_found   = free_found_reg;
        stat.scan_found   = scan_found;
        stat.scan_end     = !spend_reg && !sissue;
        stat.fill_last    = fill_last;
        stat.blk_last     = (blk_reg == BW'(NUM_BLOCKS - 1));
        stat.len_zero     = (cur_len_reg == '0);
        stat.req_zero     = (req_reg == '0);
        stat.managed_zero = (managed == '0);
        stat.op_delete    = (op_reg == cffa_pkg::OP_DELETE);
        stat.out_free     = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid        = m_tvalid_reg;
    assign out_status      = status_reg;
    assign out_first_block = first_reg;
    assign out_block_total = total_reg;

endmodule

// ===== hw/rtl/contiguous_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator: first-fit contiguous block allocator
// Keeps a one-bit-per-block allocation map and a small file directory, and
// serves create and delete requests one at a time.
// ----------------------------------------------------------------------------
//
//  Port group | Dir | Contents of one item
//  -----------+-----+------------------------------------------------------
//  s_*        | in  | tuser: operation; tdata: file_key, request_blocks
//  m_*        | out | tdata: status, first_block, block_total
//  APB        | in  | register 0 at byte 0: blocks_in_use (9 bits)
//
//  After reset a clearing pass writes every map bit to zero, one block a
//  cycle, and no request is taken until it has finished. An item is then
//  accepted, walks the directory through its memory port and is decided.
//  A create then scans the map one block a cycle until the first free run
//  fits, and marks the run, one block a cycle. A delete clears the file's
//  blocks the same way. A successful item then updates the directory, and
//  the result is loaded. A result waits in the output register while a new
//  request is accepted; the request stalls at the end only if that result
//  has still not been taken.
//
// ----------------------------------------------------------------------------
module contiguous_first_fit_allocator #(
    parameter int NUM_BLOCKS  = 256,
    parameter int DIR_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] file_key, [72:64] request_blocks, rest zero
    input  logic [0:0]  s_tuser,   // [0] operation (0 create, 1 delete)

    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [10:3] first_block, [19:11] block_total

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cffa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cffa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cffa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [cffa_pkg::CFG_W-1:0] blocks_in_use_reg;
    logic                       cfg_write;
    logic                       cfg_hit;

    cffa_pkg::cffa_cmd_t  cmd;
    cffa_pkg::cffa_stat_t stat;

    logic [cffa_pkg::STATUS_W-1:0] out_status;
    logic [cffa_pkg::FIRST_W-1:0]  out_first_block;
    logic [cffa_pkg::TOTAL_W-1:0]  out_block_total;

    // The single register is selected by paddr[2]; the low address bits are
    // byte offsets and ignored.
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == cffa_pkg::REG_BLOCKS_IN_USE);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= cffa_pkg::BLOCKS_IN_USE_RESET;
        end else if (cfg_write) begin
            blocks_in_use_reg <= pwdata[cffa_pkg::CFG_W-1:0];
        end
    end

    assign prdata = cfg_hit ? cffa_pkg::APB_DATA_W'(blocks_in_use_reg) : '0;

    cffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cffa_dpath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .DIR_ENTRIES (DIR_ENTRIES)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .blocks_in_use     (blocks_in_use_reg),
        .in_operation      (s_tuser[0]),
        .in_file_key       (s_tdata[63:0]),
        .in_request_blocks (s_tdata[72:64]),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_status        (out_status),
        .out_first_block   (out_first_block),
        .out_block_total   (out_block_total)
    );

    assign m_tdata = {4'b0000, out_block_total, out_first_block, out_status};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the contiguous first-fit allocator
// Drives create and delete requests on the request stream, programs the
// managed block count over the configuration port, and compares every result
// item with an allocation map and file directory kept in the bench itself.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_BLOCKS  = 256;
    localparam int DIR_ENTRIES = 16;
    localparam int KEY_POOL    = 24;
    localparam int CYCLE_LIMIT = 4000000;

    // One result item as the block reports it.
    typedef struct packed {
        cffa_pkg::status_t                status;
        logic [cffa_pkg::FIRST_W-1:0]     first;
        logic [cffa_pkg::TOTAL_W-1:0]     total;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cffa_pkg::APB_ADDR_W-1:0] paddr;
    logic [cffa_pkg::APB_DATA_W-1:0] pwdata;
    logic [cffa_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Bench copy of the allocator state: map, directory and register.
    logic [NUM_BLOCKS-1:0]          block_used;
    logic                           dir_valid [DIR_ENTRIES];
    logic [cffa_pkg::KEY_W-1:0]     dir_key   [DIR_ENTRIES];
    int                             dir_start [DIR_ENTRIES];
    int                             dir_len   [DIR_ENTRIES];
    logic [cffa_pkg::CFG_W-1:0]     managed_cfg;

    // Results still owed by the block, oldest first.
    alloc_result_t pending_results[$];

    logic [cffa_pkg::KEY_W-1:0] key_pool [KEY_POOL];
    int sender_idle_pct;
    int receiver_stall_pct;
    int error_count;
    int cycle_count;

    contiguous_first_fit_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .DIR_ENTRIES(DIR_ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // The watchdog covers a hung handshake anywhere in the run, including the
    // clearing pass that follows reset.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver decides afresh at every falling edge whether it stalls.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Returns the directory slot holding the key, or -1 when it is absent.
    function automatic int find_file(input logic [cffa_pkg::KEY_W-1:0] key);
        for (int e = 0; e < DIR_ENTRIES; e++) begin
            if (dir_valid[e] && dir_key[e] == key) begin
                return e;
            end
        end
        return -1;
    endfunction

    // Applies one request to the bench state and returns the result the block
    // must give for it.
    task automatic allocate_or_free(input logic op, input logic [cffa_pkg::KEY_W-1:0] key,
                                    input logic [cffa_pkg::REQ_W-1:0] req,
                                    output alloc_result_t res);
        int idx;
        int slot;
        int managed;
        int run;
        int start;
        bit found;
        idx     = find_file(key);
        slot    = -1;
        found   = 1'b0;
        start   = 0;
        run     = 0;
        // Register values above the map size are used as the whole map.
        managed = (managed_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(managed_cfg);
        if (op == cffa_pkg::OP_CREATE) begin
            for (int e = DIR_ENTRIES - 1; e >= 0; e--) begin
                if (!dir_valid[e]) begin
                    slot = e;
                end
            end
            if (idx >= 0) begin
                res = '{cffa_pkg::ST_EXISTS, 8'd0, 9'd0};
            end else if (slot < 0) begin
                res = '{cffa_pkg::ST_DIR_FULL, 8'd0, 9'd0};
            end else begin
                // A zero-sized file fits at block zero as long as any block
                // is managed; otherwise search for the lowest free run.
                if (managed != 0) begin
                    if (req == 0) begin
                        found = 1'b1;
                    end else begin
                        for (int i = 0; i < managed && !found; i++) begin
                            run = block_used[i] ? 0 : run + 1;
                            if (run >= int'(req)) begin
                                found = 1'b1;
                                start = i + 1 - int'(req);
                            end
                        end
                    end
                end
                if (!found) begin
                    res = '{cffa_pkg::ST_NO_SPACE, 8'd0, 9'd0};
                end else begin
                    for (int k = start; k < start + int'(req) && k < NUM_BLOCKS; k++) begin
                        block_used[k] = 1'b1;
                    end
                    dir_valid[slot] = 1'b1;
                    dir_key[slot]   = key;
                    dir_start[slot] = start;
                    dir_len[slot]   = int'(req);
                    res = '{cffa_pkg::ST_OK, start[cffa_pkg::FIRST_W-1:0], req};
                end
            end
        end else begin
            if (idx < 0) begin
                res = '{cffa_pkg::ST_NOT_FOUND, 8'd0, 9'd0};
            end else begin
                // A delete frees the whole file, even past the managed count.
                for (int k = dir_start[idx]; k < dir_start[idx] + dir_len[idx] && k < NUM_BLOCKS;
                     k++) begin
                    block_used[k] = 1'b0;
                end
                dir_valid[idx] = 1'b0;
                res = '{cffa_pkg::ST_OK, dir_start[idx][cffa_pkg::FIRST_W-1:0],
                        dir_len[idx][cffa_pkg::TOTAL_W-1:0]};
            end
        end
    endtask

    // Sends one request item, after a random gap, and records what the block
    // owes for it once the item has been accepted.
    task automatic send_request(input logic op, input logic [cffa_pkg::KEY_W-1:0] key,
                                input logic [cffa_pkg::REQ_W-1:0] req);
        alloc_result_t res;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, req, key};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        allocate_or_free(op, key, req, res);
        pending_results.push_back(res);
    endtask

    // Holds the sender off until every owed result has come back, then lets
    // the block settle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Writes the managed block count over the configuration port. The block
    // is drained first, so the write always lands while it is idle.
    task automatic write_managed_blocks(input logic [cffa_pkg::CFG_W-1:0] value);
        drain_results();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cffa_pkg::REG_BLOCKS_IN_USE, 2'b00};
        pwdata  <= {{(cffa_pkg::APB_DATA_W - cffa_pkg::CFG_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        managed_cfg = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Deletes every file the directory holds, so a test starts from a free map.
    task automatic clear_directory();
        logic [cffa_pkg::KEY_W-1:0] key;
        for (int e = 0; e < DIR_ENTRIES; e++) begin
            if (dir_valid[e]) begin
                key = dir_key[e];
                send_request(cffa_pkg::OP_DELETE, key, 9'd0);
            end
        end
    endtask

    // Compare every accepted result item with the oldest expectation.
    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = cffa_pkg::status_t'(m_tdata[2:0]);
            got.first  = m_tdata[10:3];
            got.total  = m_tdata[19:11];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result item %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                end
                if (got.first !== want.first) begin
                    report_mismatch($sformatf("first_block %0d, expected %0d",
                                              got.first, want.first));
                end
                if (got.total !== want.total) begin
                    report_mismatch($sformatf("block_total %0d, expected %0d",
                                              got.total, want.total));
                end
            end
        end
    end

    // Basic cases: absent key, zero-sized file, whole-map file, oversized
    // request, then a full directory and the order of checks on create.
    task automatic test_directed_basic();
        logic [cffa_pkg::KEY_W-1:0] key;
        send_request(cffa_pkg::OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0);
        send_request(cffa_pkg::OP_CREATE, 64'h0, 9'd0);
        send_request(cffa_pkg::OP_CREATE, 64'h0, 9'd5);
        send_request(cffa_pkg::OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 9'd256);
        send_request(cffa_pkg::OP_CREATE, 64'h5, 9'd1);
        send_request(cffa_pkg::OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 9'h1FF);
        send_request(cffa_pkg::OP_CREATE, 64'h5, 9'h1FF);
        // Fifteen one-block files fill the rest of the directory.
        for (int i = 0; i < DIR_ENTRIES - 1; i++) begin
            key = {$urandom, $urandom};
            send_request(cffa_pkg::OP_CREATE, key, 9'd1);
        end
        send_request(cffa_pkg::OP_CREATE, 64'hAAAA_5555_AAAA_5555, 9'd1);
        // An existing key wins over the full directory.
        send_request(cffa_pkg::OP_CREATE, 64'h0, 9'd1);
        send_request(cffa_pkg::OP_DELETE, 64'h0, 9'd0);
    endtask

    // Register edge cases: shrinking below live files, zero and one managed
    // block, and a value above the map size.
    task automatic test_register_range();
        clear_directory();
        write_managed_blocks(9'd256);
        send_request(cffa_pkg::OP_CREATE, 64'h1111_0000_0000_0001, 9'd200);
        write_managed_blocks(9'd8);
        send_request(cffa_pkg::OP_CREATE, 64'h2222, 9'd8);
        send_request(cffa_pkg::OP_CREATE, 64'h3333, 9'd0);
        // The file reaches past the managed count but is freed whole.
        send_request(cffa_pkg::OP_DELETE, 64'h1111_0000_0000_0001, 9'd0);
        send_request(cffa_pkg::OP_CREATE, 64'h2222, 9'd8);
        send_request(cffa_pkg::OP_CREATE, 64'h4444, 9'd1);
        write_managed_blocks(9'd0);
        send_request(cffa_pkg::OP_CREATE, 64'h5555, 9'd0);
        write_managed_blocks(9'd1);
        send_request(cffa_pkg::OP_CREATE, 64'h5555, 9'd0);
        send_request(cffa_pkg::OP_CREATE, 64'h6666, 9'd1);
        write_managed_blocks(9'h1FF);
        send_request(cffa_pkg::OP_CREATE, 64'h6666, 9'd256);
        send_request(cffa_pkg::OP_CREATE, 64'h6666, 9'd248);
        clear_directory();
    endtask

    // Random traffic over a small pool of keys, so the directory fills, keys
    // collide and deletes mostly hit live files.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [cffa_pkg::CFG_W-1:0] blocks,
                                       input int items);
        logic                       op;
        logic [cffa_pkg::KEY_W-1:0] key;
        logic [cffa_pkg::REQ_W-1:0] req;
        int pick;
        int base;
        write_managed_blocks(blocks);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            // Pause once mid-phase until the block has answered everything.
            if (n == items / 2) begin
                drain_results();
            end
            op  = ($urandom_range(99) < 45) ? cffa_pkg::OP_DELETE : cffa_pkg::OP_CREATE;
            key = ($urandom_range(99) < 5) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(KEY_POOL - 1)];
            if (op == cffa_pkg::OP_DELETE && $urandom_range(99) < 80) begin
                base = int'($urandom_range(DIR_ENTRIES - 1));
                for (int k = DIR_ENTRIES - 1; k >= 0; k--) begin
                    if (dir_valid[(base + k) % DIR_ENTRIES]) begin
                        key = dir_key[(base + k) % DIR_ENTRIES];
                    end
                end
            end
            pick = int'($urandom_range(99));
            if (pick < 60) begin
                req = 9'($urandom_range(16));
            end else if (pick < 85) begin
                req = 9'($urandom_range(64));
            end else if (pick < 95) begin
                req = 9'($urandom_range(256));
            end else begin
                req = 9'($urandom_range(511));
            end
            send_request(op, key, req);
        end
        drain_results();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        error_count  = 0;
        cycle_count  = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        block_used   = '0;
        managed_cfg  = cffa_pkg::BLOCKS_IN_USE_RESET;
        for (int e = 0; e < DIR_ENTRIES; e++) begin
            dir_valid[e] = 1'b0;
        end
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_basic();
        test_register_range();
        test_random_traffic(0, 0, 9'd256, 250);
        test_random_traffic(72, 0, 9'($urandom_range(1, 256)), 250);
        test_random_traffic(0, 72, 9'h1FF, 250);
        test_random_traffic(27, 27, 9'($urandom_range(32, 128)), 250);

        // Everything has been answered; give the block time to show any
        // stray result item before the verdict.
        drain_results();
        repeat (600) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== contiguous_first_fit_allocator.f =====
hw/rtl/cffa_pkg.sv
hw/rtl/cffa_ctrl.sv
hw/rtl/cffa_dpath.sv
hw/rtl/contiguous_first_fit_allocator.sv
tb/testbench.sv
